// ===== rtl/egb_pkg.sv =====
// egb_pkg: shared types, constants and the microcode rom of the extended gcd unit
// depends on nothing; used by the interfaces, egb_dp and extended_gcd_bezout
`timescale 1ns / 1ps

package egb_pkg;

  localparam int OPND_W = 31;
  localparam int COEF_W = 32;
  localparam int K_W    = 5;   // shift count, holds 0 .. OPND_W-1
  localparam int PC_W   = 3;

  typedef logic [PC_W-1:0] pc_t;

  // program addresses
  localparam pc_t S_IDLE  = 3'd0;
  localparam pc_t S_TEST  = 3'd1;
  localparam pc_t S_ALIGN = 3'd2;
  localparam pc_t S_SUB   = 3'd3;
  localparam pc_t S_SWAP  = 3'd4;
  localparam pc_t S_DONE  = 3'd5;
  localparam pc_t S_LAST  = S_DONE;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_INIT,
    OP_SHL,
    OP_SUB,
    OP_SWAP,
    OP_PUT
  } op_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_NO_START,
    C_RC_ZERO,
    C_CAN_SHIFT,
    C_K_NONZERO,
    C_REM_NONZERO,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   tgt;
  } ucode_t;

  typedef struct packed {
    op_t op;
  } dp_ctrl_t;

  typedef struct packed {
    logic rc_zero;
    logic can_shift;
    logic k_nonzero;
    logic rem_nonzero;
  } dp_stat_t;

  // control store: a taken condition jumps to tgt, otherwise the next word
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    w = '{op: OP_NOP, cond: C_NONE, tgt: S_IDLE};
    unique case (pc)
      S_IDLE:  w = '{op: OP_LOAD, cond: C_NO_START,    tgt: S_IDLE};
      S_TEST:  w = '{op: OP_INIT, cond: C_RC_ZERO,     tgt: S_DONE};
      S_ALIGN: w = '{op: OP_SHL,  cond: C_CAN_SHIFT,   tgt: S_ALIGN};
      S_SUB:   w = '{op: OP_SUB,  cond: C_K_NONZERO,   tgt: S_SUB};
      S_SWAP:  w = '{op: OP_SWAP, cond: C_REM_NONZERO, tgt: S_ALIGN};
      S_DONE:  w = '{op: OP_PUT,  cond: C_OUT_BUSY,    tgt: S_DONE};
      default: w = '{op: OP_NOP,  cond: C_NONE,        tgt: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/egb_if.sv =====
// egb_in_if and egb_out_if: valid/ready channels of the extended gcd unit
// depends on egb_pkg for the field widths
`timescale 1ns / 1ps

interface egb_in_if;
  logic                         valid;
  logic                         ready;
  logic [egb_pkg::OPND_W-1:0]   operand_a;
  logic [egb_pkg::OPND_W-1:0]   operand_b;

  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface egb_out_if;
  logic                              valid;
  logic                              ready;
  logic [egb_pkg::OPND_W-1:0]        divisor;
  logic signed [egb_pkg::COEF_W-1:0] coef_s;
  logic signed [egb_pkg::COEF_W-1:0] coef_t;

  modport source (output valid, output divisor, output coef_s, output coef_t, input ready);
  modport sink   (input valid, input divisor, input coef_s, input coef_t, output ready);
endinterface

// ===== rtl/extended_gcd_bezout.sv =====
// extended_gcd_bezout: top level, microcode sequencer and result register
// depends on egb_pkg, egb_in_if / egb_out_if and egb_dp
`timescale 1ns / 1ps

// gcd with bezout coefficients: divisor = coef_s*operand_a + coef_t*operand_b
//
// in_ch carries one beat of two 31-bit operands, out_ch one beat of the gcd and
// the two 32-bit two's complement coefficients; one result beat per input beat
// a small control store steps a shift-subtract datapath through euclid's
// algorithm; each quotient costs an align pass and a subtract pass
// one pair is worked on at a time: in_ch.ready is high only at the idle step
// the result sits in an output register; the next pair is taken while it
// waits, and the sequencer holds at its final step only if that register is
// still full when the next result is ready
// reset (rst_n low, synchronous) returns the sequencer to idle and empties the
// output register; no clearing pass is needed
// coefficients are computed modulo 2**WIDTH and then fitted to 32 bits

module extended_gcd_bezout #(
  parameter int WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  egb_in_if.sink     in_ch,
  egb_out_if.source  out_ch
);

  egb_pkg::pc_t      pc_r, pc_nxt;
  egb_pkg::ucode_t   uw;
  egb_pkg::dp_ctrl_t ctrl;
  egb_pkg::dp_stat_t stat;
  logic              jump;
  logic              out_busy;
  logic              put;

  logic [egb_pkg::OPND_W-1:0] rem_q;
  logic [WIDTH-1:0]           s_q;
  logic [WIDTH-1:0]           t_q;
  logic [WIDTH+egb_pkg::COEF_W-1:0] s_ext, t_ext;

  logic                              out_valid_r, out_valid_nxt;
  logic [egb_pkg::OPND_W-1:0]        divisor_r;
  logic [egb_pkg::COEF_W-1:0]        coef_s_r, coef_t_r;

  // current control word
  assign uw = egb_pkg::ucode_rom(pc_r);

  // output slot is free when empty or being drained this cycle
  assign out_busy = out_valid_r && !out_ch.ready;
  assign put      = (uw.op == egb_pkg::OP_PUT) && !out_busy;

  assign in_ch.ready = (uw.op == egb_pkg::OP_LOAD);

  // load only with a beat present
  assign ctrl.op = ((uw.op == egb_pkg::OP_LOAD) && !in_ch.valid) ? egb_pkg::OP_NOP : uw.op;

  // branch condition select
  always_comb begin
    case (uw.cond)
      egb_pkg::C_NO_START:    jump = !in_ch.valid;
      egb_pkg::C_RC_ZERO:     jump = stat.rc_zero;
      egb_pkg::C_CAN_SHIFT:   jump = stat.can_shift;
      egb_pkg::C_K_NONZERO:   jump = stat.k_nonzero;
      egb_pkg::C_REM_NONZERO: jump = stat.rem_nonzero;
      egb_pkg::C_OUT_BUSY:    jump = out_busy;
      default:                jump = 1'b0;
    endcase
  end

  // step counter: taken branch, else next word, wrapping after the last
  always_comb begin
    if (jump) begin
      pc_nxt = uw.tgt;
    end else if (pc_r == egb_pkg::S_LAST) begin
      pc_nxt = egb_pkg::S_IDLE;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= egb_pkg::S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  egb_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk    (clk),
    .ctrl   (ctrl),
    .opnd_a (in_ch.operand_a),
    .opnd_b (in_ch.operand_b),
    .stat   (stat),
    .rem_q  (rem_q),
    .s_q    (s_q),
    .t_q    (t_q)
  );

  // fit WIDTH-bit coefficients to the 32-bit result fields
  assign s_ext = {{egb_pkg::COEF_W{1'b0}}, s_q};
  assign t_ext = {{egb_pkg::COEF_W{1'b0}}, t_q};

  // result register: filled by the final step, emptied by an out beat
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (put) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (put) begin
      divisor_r <= rem_q;
      coef_s_r  <= s_ext[egb_pkg::COEF_W-1:0];
      coef_t_r  <= t_ext[egb_pkg::COEF_W-1:0];
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.divisor = divisor_r;
  assign out_ch.coef_s  = coef_s_r;
  assign out_ch.coef_t  = coef_t_r;

  // an accepted pair always starts the zero test next
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (pc_r == egb_pkg::S_TEST))
    else $error("sequencer did not start after input beat");

  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    put |-> (!out_valid_r || out_ch.ready))
    else $error("result register overwritten");

  // after a result is posted the sequencer is back at idle
  a_put_returns: assert property (@(posedge clk) disable iff (!rst_n)
    put |=> (pc_r == egb_pkg::S_IDLE) && out_valid_r)
    else $error("sequencer did not return to idle after result");

  // step counter stays inside the program
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= egb_pkg::S_LAST)
    else $error("step counter outside program");

endmodule

// ===== rtl/egb_dp.sv =====
// egb_dp: remainder and coefficient registers with shift-subtract division step
// depends on egb_pkg; driven by the sequencer in extended_gcd_bezout
`timescale 1ns / 1ps

module egb_dp #(
  parameter int WIDTH = 32
) (
  input  logic                        clk,
  input  egb_pkg::dp_ctrl_t           ctrl,
  input  logic [egb_pkg::OPND_W-1:0]  opnd_a,
  input  logic [egb_pkg::OPND_W-1:0]  opnd_b,
  output egb_pkg::dp_stat_t           stat,
  output logic [egb_pkg::OPND_W-1:0]  rem_q,
  output logic [WIDTH-1:0]            s_q,
  output logic [WIDTH-1:0]            t_q
);

  localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

  logic [egb_pkg::OPND_W-1:0] rp_r, rp_nxt, rc_r, rc_nxt, rsh_r, rsh_nxt;
  logic [WIDTH-1:0]           sp_r, sp_nxt, sc_r, sc_nxt, tp_r, tp_nxt, tc_r, tc_nxt;
  logic [egb_pkg::K_W-1:0]    k_r, k_nxt;

  logic [egb_pkg::OPND_W:0]   rsh2;
  logic                       can_shift;
  logic                       fits;
  logic [WIDTH-1:0]           ds;
  logic [WIDTH-1:0]           dt;

  // divisor shifted one more place still fits under the remainder
  assign rsh2      = {rsh_r, 1'b0};
  assign can_shift = rsh2 <= {1'b0, rp_r};
  assign fits      = rsh_r <= rp_r;
  // coefficient scaled by the same power of two as the divisor
  assign ds        = sc_r << k_r;
  assign dt        = tc_r << k_r;

  always_comb begin
    rp_nxt  = rp_r;
    rc_nxt  = rc_r;
    rsh_nxt = rsh_r;
    sp_nxt  = sp_r;
    sc_nxt  = sc_r;
    tp_nxt  = tp_r;
    tc_nxt  = tc_r;
    k_nxt   = k_r;
    unique case (ctrl.op)
      egb_pkg::OP_LOAD: begin
        rp_nxt = opnd_a;
        rc_nxt = opnd_b;
        // both zero gives all-zero result
        sp_nxt = ((opnd_a | opnd_b) != '0) ? ONE : '0;
        sc_nxt = '0;
        tp_nxt = '0;
        tc_nxt = ONE;
      end
      egb_pkg::OP_INIT: begin
        rsh_nxt = rc_r;
        k_nxt   = '0;
      end
      egb_pkg::OP_SHL: begin
        if (can_shift) begin
          rsh_nxt = rsh2[egb_pkg::OPND_W-1:0];
          k_nxt   = k_r + 1'b1;
        end
      end
      egb_pkg::OP_SUB: begin
        if (fits) begin
          rp_nxt = rp_r - rsh_r;
          sp_nxt = sp_r - ds;
          tp_nxt = tp_r - dt;
        end
        if (k_r != '0) begin
          rsh_nxt = rsh_r >> 1;
          k_nxt   = k_r - 1'b1;
        end
      end
      egb_pkg::OP_SWAP: begin
        rp_nxt  = rc_r;
        rc_nxt  = rp_r;
        sp_nxt  = sc_r;
        sc_nxt  = sp_r;
        tp_nxt  = tc_r;
        tc_nxt  = tp_r;
        rsh_nxt = rp_r;
        k_nxt   = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rp_r  <= rp_nxt;
    rc_r  <= rc_nxt;
    rsh_r <= rsh_nxt;
    sp_r  <= sp_nxt;
    sc_r  <= sc_nxt;
    tp_r  <= tp_nxt;
    tc_r  <= tc_nxt;
    k_r   <= k_nxt;
  end

  assign stat.rc_zero     = (rc_r == '0);
  assign stat.can_shift   = can_shift;
  assign stat.k_nonzero   = (k_r != '0);
  assign stat.rem_nonzero = (rp_r != '0);

  assign rem_q = rp_r;
  assign s_q   = sp_r;
  assign t_q   = tp_r;

endmodule

// ===== tb/tb_extended_gcd_bezout.sv =====
// tb_extended_gcd_bezout: self-checking bench for the extended gcd / bezout unit
// depends on egb_pkg, egb_in_if / egb_out_if and extended_gcd_bezout from rtl
// directed corner pairs, then random operand mixes checked against a local euclid model
`timescale 1ns / 1ps

module tb_extended_gcd_bezout;

  typedef logic [egb_pkg::OPND_W-1:0] opnd_t;
  typedef logic [egb_pkg::COEF_W-1:0] coef_t;

  localparam int          N_DIRECTED = 20;
  localparam int          N_RANDOM   = 650;
  localparam int          TAIL_WAIT  = 300;      // well past the worst pair latency
  localparam longint      CYCLE_CAP  = 1000000;  // ends a hung run as a failure
  localparam logic [30:0] OPND_MAX   = 31'h7FFFFFFF;

  // one result beat: gcd plus both coefficients as raw 32-bit patterns
  typedef struct packed {
    opnd_t divisor;
    coef_t coef_s;
    coef_t coef_t;
  } bezout_t;

  // directed row: operands, and a hand-typed result where it is obvious
  typedef struct packed {
    opnd_t   a;
    opnd_t   b;
    logic    typed;
    bezout_t res;
  } stim_row_t;

  logic clk;
  logic rst_n;

  egb_in_if  in_ch ();
  egb_out_if out_ch ();

  extended_gcd_bezout #(
    .WIDTH(32)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // results still owed by the unit, oldest first
  bezout_t     pending_bezout[$];
  int unsigned fail_count;
  longint      cycle_count;
  int unsigned send_quiet;
  int unsigned recv_quiet;

  stim_row_t directed_rows [N_DIRECTED] = '{
    // zero operands
    '{31'd0,         31'd0,         1'b1, '{31'd0,         32'd0, 32'd0}},
    '{OPND_MAX,      31'd0,         1'b1, '{OPND_MAX,      32'd1, 32'd0}},
    '{31'd0,         OPND_MAX,      1'b1, '{OPND_MAX,      32'd0, 32'd1}},
    '{31'd1,         31'd0,         1'b1, '{31'd1,         32'd1, 32'd0}},
    '{31'd0,         31'd1,         1'b1, '{31'd1,         32'd0, 32'd1}},
    // equal operands
    '{OPND_MAX,      OPND_MAX,      1'b1, '{OPND_MAX,      32'd0, 32'd1}},
    '{31'd1,         31'd1,         1'b1, '{31'd1,         32'd0, 32'd1}},
    '{31'd12345,     31'd12345,     1'b1, '{31'd12345,     32'd0, 32'd1}},
    // b divides a: one quotient step, coefficients stay 0 / 1
    '{OPND_MAX,      31'd1,         1'b1, '{31'd1,         32'd0, 32'd1}},
    '{31'h40000000,  31'h20000000,  1'b1, '{31'h20000000,  32'd0, 32'd1}},
    // the rest go through the model
    '{31'h55555555,  31'h2AAAAAAA,  1'b0, '0},
    '{31'd1,         OPND_MAX,      1'b0, '0},
    '{OPND_MAX,      31'h7FFFFFFE,  1'b0, '0},
    '{31'h7FFFFFFE,  OPND_MAX,      1'b0, '0},
    // consecutive fibonacci numbers: the longest quotient chain in 31 bits
    '{31'd1836311903, 31'd1134903170, 1'b0, '0},
    '{31'd1134903170, 31'd1836311903, 1'b0, '0},
    '{31'h40000000,  OPND_MAX,      1'b0, '0},
    '{31'd240,       31'd46,        1'b0, '0},
    '{31'd46,        31'd240,       1'b0, '0},
    '{31'd65536,     31'd65537,     1'b0, '0}
  };

  // euclid on (a, b) in that order, coefficients carried mod 2**32
  function automatic bezout_t bezout_of(input opnd_t a, input opnd_t b);
    opnd_t   r_old, r_now, r_nxt, quo;
    coef_t   s_old, s_now, s_nxt;
    coef_t   t_old, t_now, t_nxt;
    bezout_t res;
    r_old = a;
    r_now = b;
    s_old = 32'd1;
    s_now = 32'd0;
    t_old = 32'd0;
    t_now = 32'd1;
    if (a == '0 && b == '0) begin
      // both zero: everything zero, not the (0, 1, 0) the loop would leave
      res = '0;
      return res;
    end
    while (r_now != '0) begin
      quo   = r_old / r_now;
      r_nxt = r_old - quo * r_now;
      s_nxt = s_old - coef_t'(quo) * s_now;
      t_nxt = t_old - coef_t'(quo) * t_now;
      r_old = r_now;
      r_now = r_nxt;
      s_old = s_now;
      s_now = s_nxt;
      t_old = t_now;
      t_now = t_nxt;
    end
    res.divisor = r_old;
    res.coef_s  = s_old;
    res.coef_t  = t_old;
    return res;
  endfunction

  // idle cycles before the next beat: mostly drawn at random, with runs of back-to-back beats
  function automatic int unsigned idle_cycles(inout int unsigned quiet_left);
    if (quiet_left != 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      quiet_left = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  // one input beat; valid stays high across back-to-back beats
  task automatic send_pair(input opnd_t a, input opnd_t b,
                           input logic typed, input bezout_t typed_res);
    int unsigned gap;
    gap = idle_cycles(send_quiet);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    do @(posedge clk); while (!in_ch.ready);
    pending_bezout.push_back(typed ? typed_res : bezout_of(a, b));
  endtask

  // drop valid and hold off until every owed result is back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_bezout.size() != 0) @(posedge clk);
  endtask

  // free-running clock, 20 ns period
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // cycle cap: a hung handshake ends the run as a failure
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("tb_extended_gcd_bezout failed");
      $finish;
    end
  end

  // result side: random back-pressure, then compare each beat with the oldest owed result
  initial begin : result_side
    bezout_t exp_res;
    int unsigned stall;
    out_ch.ready <= 1'b0;
    recv_quiet = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = idle_cycles(recv_quiet);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (pending_bezout.size() == 0) begin
        $error("result beat with nothing owed: divisor %0d", out_ch.divisor);
        fail_count++;
      end else begin
        exp_res = pending_bezout.pop_front();
        if (out_ch.divisor !== exp_res.divisor) begin
          $error("divisor: expected %0d, got %0d", exp_res.divisor, out_ch.divisor);
          fail_count++;
        end
        if (out_ch.coef_s !== exp_res.coef_s) begin
          $error("coef_s: expected %0d, got %0d",
                 $signed(exp_res.coef_s), $signed(out_ch.coef_s));
          fail_count++;
        end
        if (out_ch.coef_t !== exp_res.coef_t) begin
          $error("coef_t: expected %0d, got %0d",
                 $signed(exp_res.coef_t), $signed(out_ch.coef_t));
          fail_count++;
        end
      end
    end
  end

  // input side: reset, directed corners, then the random mix
  initial begin : operand_side
    opnd_t       a, b, tmp;
    longint      fib_lo, fib_hi, fib_nx;
    int unsigned kind, g, n;
    fail_count      = 0;
    send_quiet      = 0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operand_a <= '0;
    in_ch.operand_b <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_pair(directed_rows[i].a, directed_rows[i].b,
                directed_rows[i].typed, directed_rows[i].res);
    end
    drain_results();

    for (int i = 0; i < N_RANDOM; i++) begin
      kind = $urandom_range(0, 15);
      case (kind) inside
        [0:5], 14, 15: begin
          // full-range operands, top bit included
          a = opnd_t'($urandom);
          b = opnd_t'($urandom);
        end
        6, 7: begin
          // random magnitudes so that short and long chains both show up
          a = opnd_t'($urandom >> $urandom_range(1, 31));
          b = opnd_t'($urandom >> $urandom_range(1, 31));
        end
        8: begin
          a = opnd_t'($urandom_range(0, 255));
          b = opnd_t'($urandom_range(0, 255));
        end
        9: begin
          // shared factor g drawn from 1 .. 32768, so the gcd is mostly well above 1
          g = $urandom_range(1, 32768);
          a = opnd_t'(g * $urandom_range(0, 32767));
          b = opnd_t'(g * $urandom_range(0, 32767));
        end
        10: begin
          // one operand zero
          a = opnd_t'($urandom);
          b = '0;
          if ($urandom_range(0, 1) == 1) begin
            b = a;
            a = '0;
          end
        end
        11: begin
          a = opnd_t'($urandom);
          b = a;
        end
        12: begin
          // consecutive fibonacci pair, either order
          n      = $urandom_range(2, 46);
          fib_lo = 0;
          fib_hi = 1;
          for (int k = 1; k < n; k++) begin
            fib_nx = fib_lo + fib_hi;
            fib_lo = fib_hi;
            fib_hi = fib_nx;
          end
          a = fib_hi[egb_pkg::OPND_W-1:0];
          b = fib_lo[egb_pkg::OPND_W-1:0];
          if ($urandom_range(0, 1) == 1) begin
            tmp = a;
            a   = b;
            b   = tmp;
          end
        end
        default: begin
          // one operand an exact multiple of the other
          b = opnd_t'($urandom_range(1, 65536));
          a = opnd_t'(b * $urandom_range(0, 32767));
          if ($urandom_range(0, 1) == 1) begin
            tmp = a;
            a   = b;
            b   = tmp;
          end
        end
      endcase
      send_pair(a, b, 1'b0, '0);
      // hold the sender off once mid-run until the unit has caught up
      if (i == N_RANDOM / 2) drain_results();
    end

    drain_results();
    repeat (TAIL_WAIT) @(posedge clk);
    if (fail_count == 0 && pending_bezout.size() == 0) begin
      $display("tb_extended_gcd_bezout passed");
    end else begin
      $display("tb_extended_gcd_bezout failed");
    end
    $finish;
  end

endmodule
